### hw/rtl/irad_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irad_pkg: shared types and constants for the IR range average block
// Widths, reset values, register indexes, status codes and the records that
// pass between the front end, the job queue and the distance back end.
// ----------------------------------------------------------------------------
package irad_pkg;

	localparam int WINDOW_LENGTH = 5;

	localparam int SAMPLE_W    = 10;
	localparam int SUM_W       = 16;
	localparam int NUM_W       = 16;
	localparam int CM_W        = 8;
	localparam int TENTHS_W    = 16;
	localparam int WHOLE_W     = 13;
	localparam int DIGIT_W     = 4;
	localparam int STATUS_W    = 3;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;

	localparam int SLOT_W = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;
	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW_LENGTH - 1);
	localparam logic [SUM_W-1:0] WIN_LEN_SUM = SUM_W'(WINDOW_LENGTH);

	// Average by reciprocal: sum * ceil(2^S / N) >> S is exact for every
	// 16-bit sum when S = 16 + ceil(log2 N).
	localparam int AVG_SHIFT  = SUM_W + $clog2(WINDOW_LENGTH);
	localparam int AVG_MULT_W = SUM_W + 1;
	localparam longint AVG_MULT_L =
		((longint'(1) << AVG_SHIFT) + longint'(WINDOW_LENGTH) - 1) / longint'(WINDOW_LENGTH);
	localparam logic [AVG_MULT_W-1:0] AVG_MULT = AVG_MULT_W'(AVG_MULT_L);
	localparam int AVG_PROD_W = SUM_W + AVG_MULT_W;

	// Tenths to whole centimetres: x * 52429 >> 19 is exact for 16-bit x.
	localparam logic [TENTHS_W-1:0] DIV10_MULT = 16'd52429;
	localparam int DIV10_SHIFT  = 19;
	localparam int DIV10_PROD_W = 2 * TENTHS_W;

	localparam int DIV_CNT_W = $clog2(NUM_W);
	localparam logic [DIV_CNT_W-1:0] DIV_CNT_LAST = DIV_CNT_W'(NUM_W - 1);

	localparam logic [SAMPLE_W-1:0] VALID_LOW_RST   = 10'd20;
	localparam logic [SAMPLE_W-1:0] VALID_HIGH_RST  = 10'd1000;
	localparam logic [SAMPLE_W-1:0] OFFSET_RST      = 10'd20;
	localparam logic [NUM_W-1:0]    NUMERATOR_RST   = 16'd48000;
	localparam logic [CM_W-1:0]     NEAR_LIMIT_RST  = 8'd20;
	localparam logic [CM_W-1:0]     FAR_LIMIT_RST   = 8'd80;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_VALID_LOW  = 3'd0,
		REG_VALID_HIGH = 3'd1,
		REG_OFFSET     = 3'd2,
		REG_NUMERATOR  = 3'd3,
		REG_NEAR_LIMIT = 3'd4,
		REG_FAR_LIMIT  = 3'd5
	} cfg_reg_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK        = 3'd0,
		STATUS_INVALID   = 3'd1,
		STATUS_CALC_ERR  = 3'd2,
		STATUS_TOO_CLOSE = 3'd3,
		STATUS_TOO_FAR   = 3'd4
	} status_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] valid_low;
		logic [SAMPLE_W-1:0] valid_high;
		logic [SAMPLE_W-1:0] sample_offset;
		logic [NUM_W-1:0]    distance_numerator;
		logic [CM_W-1:0]     near_limit_cm;
		logic [CM_W-1:0]     far_limit_cm;
	} cfg_t;

	// One classified word handed from the front end to the back end.
	typedef struct packed {
		logic [SAMPLE_W-1:0] raw;
		logic [SAMPLE_W-1:0] avg;
		status_t             status;
		logic                need_div;
		logic [SAMPLE_W-1:0] divisor;
	} job_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_DIV,
		B_SCALE,
		B_DIGIT,
		B_DONE
	} back_state_t;

endpackage

### hw/rtl/irad_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irad_front: window update and classification
// Keeps the sample ring and running sum, forms the truncated average and
// sorts each word into invalid, calculation error or needs a division.
// ----------------------------------------------------------------------------
module irad_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  irad_pkg::cfg_t                cfg,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [irad_pkg::SAMPLE_W-1:0] sample,
	output logic                          job_valid,
	input  logic                          job_ready,
	output irad_pkg::job_t                job
);

	logic [irad_pkg::SAMPLE_W-1:0] ring_q [irad_pkg::WINDOW_LENGTH];
	logic [irad_pkg::SUM_W-1:0]    sum_q;
	logic [irad_pkg::SLOT_W-1:0]   slot_q;
	logic                          primed_q;

	logic                          v_s1, v_s2;
	logic [irad_pkg::SAMPLE_W-1:0] raw_s1, raw_s2, avg_s2;

	logic                            accept;
	logic [irad_pkg::SUM_W-1:0]      sum_next;
	logic [irad_pkg::SLOT_W-1:0]     slot_next;
	logic [irad_pkg::AVG_PROD_W-1:0] avg_prod;

	assign in_ready = !v_s1 && !v_s2;
	assign accept   = in_valid && in_ready;

	assign slot_next = (slot_q == irad_pkg::SLOT_LAST) ? '0 : slot_q + 1'b1;

	always_comb begin
		if (!primed_q) begin
			sum_next = irad_pkg::SUM_W'({6'd0, sample} * irad_pkg::WIN_LEN_SUM);
		end else begin
			sum_next = sum_q - {6'd0, ring_q[slot_q]} + {6'd0, sample};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q    <= '0;
			slot_q   <= '0;
			primed_q <= 1'b0;
		end else if (accept) begin
			sum_q    <= sum_next;
			primed_q <= 1'b1;
			// A fill writes slot zero too, so the next slot is one past it.
			slot_q   <= primed_q ? slot_next :
				((irad_pkg::SLOT_LAST == '0) ? '0 : irad_pkg::SLOT_W'(1));
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < irad_pkg::WINDOW_LENGTH; i++) begin
			if (accept && (!primed_q || slot_q == irad_pkg::SLOT_W'(i))) begin
				ring_q[i] <= sample;
			end
		end
	end

	assign avg_prod = irad_pkg::AVG_PROD_W'(sum_q) * irad_pkg::AVG_PROD_W'(irad_pkg::AVG_MULT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (accept) begin
				v_s1 <= 1'b1;
			end else if (v_s1 && !v_s2) begin
				v_s1 <= 1'b0;
			end
			if (v_s1 && !v_s2) begin
				v_s2 <= 1'b1;
			end else if (v_s2 && job_ready) begin
				v_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			raw_s1 <= sample;
		end
		if (v_s1 && !v_s2) begin
			raw_s2 <= raw_s1;
			avg_s2 <= irad_pkg::SAMPLE_W'(avg_prod >> irad_pkg::AVG_SHIFT);
		end
	end

	always_comb begin
		job.raw      = raw_s2;
		job.avg      = avg_s2;
		job.divisor  = avg_s2 - cfg.sample_offset;
		job.need_div = 1'b0;
		if (avg_s2 < cfg.valid_low || avg_s2 > cfg.valid_high) begin
			job.status = irad_pkg::STATUS_INVALID;
		end else if (avg_s2 <= cfg.sample_offset) begin
			job.status = irad_pkg::STATUS_CALC_ERR;
		end else begin
			job.status   = irad_pkg::STATUS_OK;
			job.need_div = 1'b1;
		end
	end

	assign job_valid = v_s2;

endmodule

### hw/rtl/irad_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irad_queue: two-entry job queue
// Decouples the front end from the divider so each side stalls on its own.
// ----------------------------------------------------------------------------
module irad_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_valid,
	output logic           wr_ready,
	input  irad_pkg::job_t wr_job,
	output logic           rd_valid,
	input  logic           rd_ready,
	output irad_pkg::job_t rd_job
);

	irad_pkg::job_t entry_q [2];
	logic           wr_ptr_q, rd_ptr_q;
	logic [1:0]     count_q;
	logic           push, pop;

	assign wr_ready = (count_q != 2'd2);
	assign rd_valid = (count_q != 2'd0);
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;
	assign rd_job   = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wr_job;
		end
	end

endmodule

### hw/rtl/irad_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irad_back: distance division and result register
// Radix-2 restoring divider, tenths split by reciprocal, limit checks and
// the output register of the result channel.
// ----------------------------------------------------------------------------
module irad_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  irad_pkg::cfg_t                  cfg,
	input  logic                            job_valid,
	output logic                            job_ready,
	input  irad_pkg::job_t                  job,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [irad_pkg::SAMPLE_W-1:0]   raw_echo,
	output logic [irad_pkg::SAMPLE_W-1:0]   average,
	output logic [irad_pkg::STATUS_W-1:0]   status,
	output logic [irad_pkg::TENTHS_W-1:0]   distance_tenths,
	output logic [irad_pkg::WHOLE_W-1:0]    distance_whole_cm,
	output logic [irad_pkg::DIGIT_W-1:0]    distance_tenth_digit
);

	irad_pkg::back_state_t state_q, state_next;

	logic [irad_pkg::SAMPLE_W-1:0]     raw_q, avg_q, div_q, rem_q;
	irad_pkg::status_t                 status_q;
	logic [irad_pkg::TENTHS_W-1:0]     quo_q;
	logic [irad_pkg::WHOLE_W-1:0]      whole_q;
	logic [irad_pkg::DIGIT_W-1:0]      digit_q;
	logic [irad_pkg::DIV_CNT_W-1:0]    cnt_q;
	logic [irad_pkg::DIV10_PROD_W-1:0] prod_q;
	logic                              out_valid_q;

	logic                          take_job, load_out, out_free;
	logic [irad_pkg::SAMPLE_W:0]   shifted, diff;
	logic                          fits;
	logic [irad_pkg::WHOLE_W-1:0]  whole;
	logic [irad_pkg::TENTHS_W-1:0] whole_ten;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_next = state_q;
		case (state_q)
			irad_pkg::B_IDLE: begin
				if (job_valid) begin
					state_next = job.need_div ? irad_pkg::B_DIV : irad_pkg::B_DONE;
				end
			end
			irad_pkg::B_DIV: begin
				if (cnt_q == '0) begin
					state_next = irad_pkg::B_SCALE;
				end
			end
			irad_pkg::B_SCALE: state_next = irad_pkg::B_DIGIT;
			irad_pkg::B_DIGIT: state_next = irad_pkg::B_DONE;
			irad_pkg::B_DONE: begin
				if (out_free) begin
					state_next = irad_pkg::B_IDLE;
				end
			end
			default: state_next = irad_pkg::B_IDLE;
		endcase
	end

	always_comb begin
		job_ready = (state_q == irad_pkg::B_IDLE);
		load_out  = (state_q == irad_pkg::B_DONE) && out_free;
	end

	assign take_job = job_valid && job_ready;

	// One quotient bit a cycle; the remainder always stays below the divisor.
	assign shifted = {rem_q, quo_q[irad_pkg::TENTHS_W-1]};
	assign fits    = shifted >= {1'b0, div_q};
	assign diff    = shifted - {1'b0, div_q};

	assign whole     = irad_pkg::WHOLE_W'(prod_q >> irad_pkg::DIV10_SHIFT);
	assign whole_ten = irad_pkg::TENTHS_W'({whole, 3'b000}) + irad_pkg::TENTHS_W'({whole, 1'b0});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= irad_pkg::B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			irad_pkg::B_IDLE: begin
				if (take_job) begin
					raw_q    <= job.raw;
					avg_q    <= job.avg;
					status_q <= job.status;
					div_q    <= job.divisor;
					rem_q    <= '0;
					quo_q    <= job.need_div ? cfg.distance_numerator : '0;
					whole_q  <= '0;
					digit_q  <= '0;
					cnt_q    <= irad_pkg::DIV_CNT_LAST;
				end
			end
			irad_pkg::B_DIV: begin
				rem_q <= fits ? diff[irad_pkg::SAMPLE_W-1:0] : shifted[irad_pkg::SAMPLE_W-1:0];
				quo_q <= {quo_q[irad_pkg::TENTHS_W-2:0], fits};
				cnt_q <= cnt_q - 1'b1;
			end
			irad_pkg::B_SCALE: begin
				prod_q <= irad_pkg::DIV10_PROD_W'(quo_q) *
					irad_pkg::DIV10_PROD_W'(irad_pkg::DIV10_MULT);
			end
			irad_pkg::B_DIGIT: begin
				whole_q <= whole;
				digit_q <= irad_pkg::DIGIT_W'(quo_q - whole_ten);
				if (whole < irad_pkg::WHOLE_W'(cfg.near_limit_cm)) begin
					status_q <= irad_pkg::STATUS_TOO_CLOSE;
				end else if (whole > irad_pkg::WHOLE_W'(cfg.far_limit_cm)) begin
					status_q <= irad_pkg::STATUS_TOO_FAR;
				end else begin
					status_q <= irad_pkg::STATUS_OK;
				end
			end
			default: begin
			end
		endcase
		if (load_out) begin
			raw_echo             <= raw_q;
			average              <= avg_q;
			status               <= status_q;
			distance_tenths      <= quo_q;
			distance_whole_cm    <= whole_q;
			distance_tenth_digit <= digit_q;
		end
	end

	assign out_valid = out_valid_q;

	a_div_ends: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == irad_pkg::B_DIV && cnt_q == '0 |=> state_q == irad_pkg::B_SCALE)
		else $error("divider overran its step count");

	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> distance_tenth_digit <= irad_pkg::DIGIT_W'(9))
		else $error("tenth digit out of range");

	a_split_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (17'(distance_whole_cm) * 17'd10 + 17'(distance_tenth_digit))
			== 17'(distance_tenths))
		else $error("whole and tenth digit disagree with tenths");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == irad_pkg::STATUS_INVALID || status == irad_pkg::STATUS_CALC_ERR)
		|-> distance_tenths == '0)
		else $error("distance reported on an error status");

endmodule

### hw/rtl/ir_range_average_and_distance.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ir_range_average_and_distance: IR range moving average and distance
// Averages IR sensor samples over a window and converts the average into a
// status code and a distance in tenths of a centimetre.
// ----------------------------------------------------------------------------
// Usage:
// Samples enter on the in_valid / in_ready channel, one 10-bit word each.
// Every sample produces exactly one result word on out_valid / out_ready.
// The front end updates the window ring and running sum, forms the truncated
// average and classifies the word; it takes a new sample only after the last
// word has passed into the two-entry job queue.
// The back end pops one job at a time. A word that needs a distance passes
// the radix-2 divider, then the scale and digit steps and the done state;
// invalid or calculation-error words go straight to the done state. A new job
// is taken only once the last result has been loaded into the output register.
// A stalled receiver holds the result in the output register; the back end
// then waits, the queue fills, and in_ready drops once the front end is full.
// Reset clears the window (the first sample after reset fills every slot),
// empties the pipeline and queue, and loads the default thresholds.
// User writes registers via cfg_we/index/wdata only while idle; not enforced.
// ----------------------------------------------------------------------------
module ir_range_average_and_distance (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [irad_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [irad_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [irad_pkg::SAMPLE_W-1:0]      sample,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [irad_pkg::SAMPLE_W-1:0]      raw_echo,
	output logic [irad_pkg::SAMPLE_W-1:0]      average,
	output logic [irad_pkg::STATUS_W-1:0]      status,
	output logic [irad_pkg::TENTHS_W-1:0]      distance_tenths,
	output logic [irad_pkg::WHOLE_W-1:0]       distance_whole_cm,
	output logic [irad_pkg::DIGIT_W-1:0]       distance_tenth_digit
);

	irad_pkg::cfg_t cfg_q;

	// Register file. Values are truncated to the register width, and an
	// index outside the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.valid_low          <= irad_pkg::VALID_LOW_RST;
			cfg_q.valid_high         <= irad_pkg::VALID_HIGH_RST;
			cfg_q.sample_offset      <= irad_pkg::OFFSET_RST;
			cfg_q.distance_numerator <= irad_pkg::NUMERATOR_RST;
			cfg_q.near_limit_cm      <= irad_pkg::NEAR_LIMIT_RST;
			cfg_q.far_limit_cm       <= irad_pkg::FAR_LIMIT_RST;
		end else if (cfg_we) begin
			case (irad_pkg::cfg_reg_t'(cfg_index))
				irad_pkg::REG_VALID_LOW:  cfg_q.valid_low <= cfg_wdata[irad_pkg::SAMPLE_W-1:0];
				irad_pkg::REG_VALID_HIGH: cfg_q.valid_high <= cfg_wdata[irad_pkg::SAMPLE_W-1:0];
				irad_pkg::REG_OFFSET:     cfg_q.sample_offset <= cfg_wdata[irad_pkg::SAMPLE_W-1:0];
				irad_pkg::REG_NUMERATOR:  cfg_q.distance_numerator <= cfg_wdata;
				irad_pkg::REG_NEAR_LIMIT: cfg_q.near_limit_cm <= cfg_wdata[irad_pkg::CM_W-1:0];
				irad_pkg::REG_FAR_LIMIT:  cfg_q.far_limit_cm <= cfg_wdata[irad_pkg::CM_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Front end to queue, queue to back end.
	logic           fq_valid, fq_ready, qb_valid, qb_ready;
	irad_pkg::job_t fq_job, qb_job;

	irad_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.sample    (sample),
		.job_valid (fq_valid),
		.job_ready (fq_ready),
		.job       (fq_job)
	);

	irad_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (fq_valid),
		.wr_ready (fq_ready),
		.wr_job   (fq_job),
		.rd_valid (qb_valid),
		.rd_ready (qb_ready),
		.rd_job   (qb_job)
	);

	irad_back u_back (
		.clk                  (clk),
		.arst_n               (arst_n),
		.cfg                  (cfg_q),
		.job_valid            (qb_valid),
		.job_ready            (qb_ready),
		.job                  (qb_job),
		.out_valid            (out_valid),
		.out_ready            (out_ready),
		.raw_echo             (raw_echo),
		.average              (average),
		.status               (status),
		.distance_tenths      (distance_tenths),
		.distance_whole_cm    (distance_whole_cm),
		.distance_tenth_digit (distance_tenth_digit)
	);

endmodule
